[src/pbs_pkg.sv]
// Shared types and constants for the priority batch scheduler.
// Holds the transaction structs, the job entry layout and the controller states.
// Depends on nothing; every other file of the block uses it.
package pbs_pkg;

   localparam int MAX_JOBS_DEFAULT = 16;

   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;
   localparam int ID_W    = 5;
   localparam int TIME_W  = 20;

   typedef struct packed {
      logic [BURST_W-1:0] burst_time;
      logic [PRIO_W-1:0]  job_priority;
      logic               last_job;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]    job_id;
      logic [BURST_W-1:0] job_burst;
      logic [PRIO_W-1:0]  job_prio;
      logic [TIME_W-1:0]  wait_time;
      logic [TIME_W-1:0]  turnaround;
      logic               last_result;
   } rsp_type;

   // One job as it sits in the sorted store.
   typedef struct packed {
      logic [ID_W-1:0]    tag;
      logic [PRIO_W-1:0]  prio;
      logic [BURST_W-1:0] burst;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PLACE,
      ST_DRAIN_RD,
      ST_DRAIN_LOAD
   } state_type;

endpackage

[src/priority_batch_scheduler.sv]
// Priority batch scheduler: non-preemptive priority scheduling of a batch of jobs.
//
// Usage: jobs arrive as transactions on the req_ channel (req_valid, req_stall, req_data),
// each with a burst time, a priority number and a last_job flag. The block tags each job
// with its arrival number starting at 1 and inserts it into a store kept sorted by
// ascending priority number; equal priorities keep arrival order. When the last job of
// a batch is taken, or the store becomes full, the batch is emitted on the rsp_ channel,
// one transaction per job, with the running wait time and the turnaround time. The final
// result of a batch carries last_result.
// Insertion: the first job of a batch is written straight into the front slot. Each later
// job moves up by one every stored job of higher priority number, as the insertion walks
// the store one entry per cycle, and then takes the freed slot.
// Each result takes a store read, then an output register load. req_stall is
// high while a job is being inserted or a batch is being drained.
// Reset clears the job count, the time accumulator and the output valid; the store
// contents need no clearing because only entries of the current batch are ever read.
// A stall on rsp_ holds the output register; the drain waits on it and the read data
// stays registered until the output register frees up. New jobs are taken again once
// the final result of a batch sits in the output register.
module priority_batch_scheduler #(
   parameter int MAX_JOBS = pbs_pkg::MAX_JOBS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pbs_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pbs_pkg::rsp_type  rsp_data
);

   // Index width for the store and width of the job count, which must hold MAX_JOBS.
   localparam int IW = $clog2(MAX_JOBS);
   localparam int CW = $clog2(MAX_JOBS + 1);

   pbs_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [IW-1:0]      pos_ff, pos_in;
   logic [IW-1:0]      k_ff, k_in;
   pbs_pkg::entry_type new_ff, new_in;
   logic               done_ff, done_in;
   logic [pbs_pkg::TIME_W-1:0] acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   pbs_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   pbs_pkg::entry_type wr_data;
   logic               rd_en;
   logic [IW-1:0]      rd_addr;
   pbs_pkg::entry_type rd_data;

   logic [CW-1:0]      next_cnt;
   logic [IW-1:0]      slot;
   logic [IW-1:0]      pos_m1;
   logic               out_free;
   logic               load_rsp;
   logic               drain_last;
   logic [pbs_pkg::TIME_W-1:0] acc_sum;

   pbs_job_ram #(
      .DEPTH (MAX_JOBS),
      .AW    (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign next_cnt   = cnt_ff + CW'(1);
   assign slot       = IW'(cnt_ff);
   assign pos_m1     = pos_ff - IW'(1);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign drain_last = (CW'(k_ff) + CW'(1)) == cnt_ff;
   assign acc_sum    = acc_ff + pbs_pkg::TIME_W'(rd_data.burst);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbs_pkg::ST_IDLE;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         k_ff         <= '0;
         done_ff      <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         k_ff         <= k_in;
         done_ff      <= done_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      new_ff      <= new_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      done_in      = done_ff;
      acc_in       = acc_ff;
      new_in       = new_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = new_ff;
      rd_en        = 1'b0;
      rd_addr      = pos_m1;
      load_rsp     = 1'b0;
      req_stall    = 1'b1;

      case (state_ff)
         pbs_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               new_in.tag   = pbs_pkg::ID_W'(next_cnt);
               new_in.prio  = req_data.job_priority;
               new_in.burst = req_data.burst_time;
               done_in      = req_data.last_job || (next_cnt == CW'(MAX_JOBS));
               pos_in       = slot;
               if (cnt_ff == '0) begin
                  // First job of a batch goes straight into the front slot.
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = new_in;
                  cnt_in   = next_cnt;
                  state_in = done_in ? pbs_pkg::ST_DRAIN_RD : pbs_pkg::ST_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = slot - IW'(1);
                  state_in = pbs_pkg::ST_SHIFT;
               end
            end
         end

         pbs_pkg::ST_SHIFT: begin
            // The entry below the hole is in rd_data; strictly greater priority numbers
            // move up by one, which keeps equal priorities in arrival order.
            if (rd_data.prio > new_ff.prio) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff;
               wr_data = rd_data;
               pos_in  = pos_m1;
               if (pos_m1 == '0) begin
                  state_in = pbs_pkg::ST_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = pos_m1 - IW'(1);
               end
            end else begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff;
               wr_data  = new_ff;
               cnt_in   = next_cnt;
               state_in = done_ff ? pbs_pkg::ST_DRAIN_RD : pbs_pkg::ST_IDLE;
            end
         end

         pbs_pkg::ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = new_ff;
            cnt_in   = next_cnt;
            state_in = done_ff ? pbs_pkg::ST_DRAIN_RD : pbs_pkg::ST_IDLE;
         end

         pbs_pkg::ST_DRAIN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = k_ff;
            state_in = pbs_pkg::ST_DRAIN_LOAD;
         end

         pbs_pkg::ST_DRAIN_LOAD: begin
            if (out_free) begin
               load_rsp                = 1'b1;
               rsp_valid_in            = 1'b1;
               rsp_data_in.job_id      = rd_data.tag;
               rsp_data_in.job_burst   = rd_data.burst;
               rsp_data_in.job_prio    = rd_data.prio;
               rsp_data_in.wait_time   = acc_ff;
               rsp_data_in.turnaround  = acc_sum;
               rsp_data_in.last_result = drain_last;
               if (drain_last) begin
                  cnt_in   = '0;
                  acc_in   = '0;
                  k_in     = '0;
                  state_in = pbs_pkg::ST_IDLE;
               end else begin
                  acc_in   = acc_sum;
                  k_in     = k_ff + IW'(1);
                  state_in = pbs_pkg::ST_DRAIN_RD;
               end
            end
         end

         default: begin
            state_in = pbs_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A full store always triggers a drain, so an idle block never holds MAX_JOBS jobs.
   a_count_below_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == pbs_pkg::ST_IDLE |-> cnt_ff < CW'(MAX_JOBS))
      else $error("job count reached the store depth while idle");

   // Loading the final result returns the batch state to empty.
   a_batch_cleared: assert property (@(posedge clock) disable iff (reset)
      load_rsp && drain_last |=>
         state_ff == pbs_pkg::ST_IDLE && cnt_ff == '0 && acc_ff == '0)
      else $error("batch state not cleared after the final result");

   // The turnaround in the output register is always wait time plus burst.
   a_turnaround_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.turnaround ==
         pbs_pkg::TIME_W'(rsp_data_ff.wait_time + pbs_pkg::TIME_W'(rsp_data_ff.job_burst)))
      else $error("turnaround does not match wait time plus burst");

   // The insertion walk never runs past the front slot.
   a_shift_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == pbs_pkg::ST_SHIFT |-> pos_ff != '0)
      else $error("insertion walk at the front slot");

   // A load into the output register only happens when the previous result has left.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> !(rsp_valid_ff && rsp_stall))
      else $error("output register overwritten while stalled");

endmodule

[src/pbs_job_ram.sv]
// Job store of the priority batch scheduler: one write port, one registered read port.
// Depends on pbs_pkg for the entry layout.
module pbs_job_ram #(
   parameter int DEPTH = pbs_pkg::MAX_JOBS_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  pbs_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output pbs_pkg::entry_type  rd_data
);

   pbs_pkg::entry_type mem [DEPTH];
   pbs_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read so a stalled consumer sees it stay put.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[tb/sv/priority_batch_checker.sv]
// Scoreboard for the priority batch scheduler: watches both channels, predicts each batch.
// Collects accepted jobs, orders each finished batch and compares every result field.
// Depends on pbs_pkg for the transaction structs and field widths.
module priority_batch_checker #(
   parameter int MAX_JOBS = pbs_pkg::MAX_JOBS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  pbs_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  pbs_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   import pbs_pkg::*;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
   } job_rec_type;

   job_rec_type held_jobs[$];
   rsp_type     due_results[$];

   initial begin
      fail_count      = 0;
      pending_results = 0;
   end

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want, input int job);
      if (got !== want) begin
         report_mismatch($sformatf("job %0d %s is %0h, expected %0h", job, name, got, want));
      end
   endtask

   // Stable ordering by ascending priority number, then the running wait time.
   task automatic schedule_batch();
      job_rec_type        sorted_jobs[$];
      int                 pos;
      logic [TIME_W-1:0]  elapsed;
      rsp_type            res;
      foreach (held_jobs[i]) begin
         pos = sorted_jobs.size();
         while (pos > 0 && sorted_jobs[pos-1].prio > held_jobs[i].prio) pos--;
         sorted_jobs.insert(pos, held_jobs[i]);
      end
      elapsed = '0;
      foreach (sorted_jobs[k]) begin
         res.job_id      = sorted_jobs[k].id;
         res.job_burst   = sorted_jobs[k].burst;
         res.job_prio    = sorted_jobs[k].prio;
         res.wait_time   = elapsed;
         res.turnaround  = elapsed + TIME_W'(sorted_jobs[k].burst);
         res.last_result = (k == sorted_jobs.size() - 1);
         due_results.push_back(res);
         elapsed = res.turnaround;
      end
      held_jobs.delete();
   endtask

   // A full store closes the batch just as the last flag does.
   task automatic take_job(input req_type job);
      job_rec_type rec;
      rec.id    = ID_W'(held_jobs.size() + 1);
      rec.burst = job.burst_time;
      rec.prio  = job.job_priority;
      held_jobs.push_back(rec);
      if (job.last_job || held_jobs.size() >= MAX_JOBS) begin
         schedule_batch();
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      int      job;
      if (due_results.size() == 0) begin
         report_mismatch($sformatf("result for job %0d with none expected", got.job_id));
         return;
      end
      want = due_results.pop_front();
      job  = int'(want.job_id);
      check_field("job_id", 32'(got.job_id), 32'(want.job_id), job);
      check_field("job_burst", 32'(got.job_burst), 32'(want.job_burst), job);
      check_field("job_prio", 32'(got.job_prio), 32'(want.job_prio), job);
      check_field("wait_time", 32'(got.wait_time), 32'(want.wait_time), job);
      check_field("turnaround", 32'(got.turnaround), 32'(want.turnaround), job);
      check_field("last_result", 32'(got.last_result), 32'(want.last_result), job);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            take_job(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            check_result(rsp_data);
         end
      end
      pending_results = due_results.size();
   end

endmodule

[tb/sv/priority_batch_scheduler_test.sv]
// Top of the priority batch scheduler testbench: clock, reset, stimulus and verdict.
// Drives job transactions and result back-pressure; the checker module does the scoring.
// Depends on pbs_pkg, priority_batch_scheduler and priority_batch_checker.
module priority_batch_scheduler_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pbs_pkg::*;

   localparam int JOB_SLOTS = MAX_JOBS_DEFAULT;
   // A job insertion can walk the whole store, so this covers any work still in flight.
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_JOBS_PER_PHASE = 110;

   // How the priorities of one random batch are picked.
   typedef enum int {
      PRIO_SPREAD,
      PRIO_NARROW,
      PRIO_SAME,
      PRIO_EXTREME
   } prio_pattern_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending_results;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_count = 0;
   int jobs_sent = 0;

   always #5 clock = ~clock;

   priority_batch_scheduler u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   priority_batch_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   // The receiver stalls at random, each cycle with the chance set for the current phase.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offers one job and holds it until the block takes the transaction. Idle cycles come
   // only before valid rises, so a stalled payload never changes. Valid is left high on
   // return; the next call either replaces the payload or lowers valid.
   task automatic send_job(input logic [BURST_W-1:0] burst, input logic [PRIO_W-1:0] prio,
                           input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid             = 1'b1;
      req_data.burst_time   = burst;
      req_data.job_priority = prio;
      req_data.last_job     = last;
      do @(posedge clock); while (req_stall);
      jobs_sent++;
   endtask

   // Stops sending and waits until every predicted result has been seen, then lets the
   // block settle. The watchdog bounds the wait.
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One random batch. Most batches end on the last flag; some fill the store without it.
   // Short batches are favored so that batch boundaries come often.
   task automatic run_random_batch();
      int               size;
      bit               fill_store;
      prio_pattern_type pattern;
      logic [PRIO_W-1:0]  base_prio;
      logic [PRIO_W-1:0]  prio;
      logic [BURST_W-1:0] burst;
      fill_store = ($urandom_range(99) < 15);
      if (fill_store) begin
         size = JOB_SLOTS;
      end else if ($urandom_range(3) == 0) begin
         size = $urandom_range(1, 3);
      end else begin
         size = $urandom_range(1, JOB_SLOTS);
      end
      pattern   = prio_pattern_type'($urandom_range(3));
      base_prio = PRIO_W'($urandom_range(255));
      for (int i = 0; i < size; i++) begin
         case (pattern)
            PRIO_SPREAD:  prio = PRIO_W'($urandom_range(255));
            PRIO_NARROW:  prio = base_prio ^ PRIO_W'($urandom_range(3));
            PRIO_SAME:    prio = base_prio;
            default:      prio = $urandom_range(1) ? '1 : '0;
         endcase
         case ($urandom_range(9))
            0:       burst = '0;
            1:       burst = '1;
            default: burst = BURST_W'($urandom_range(16'hFFFF));
         endcase
         send_job(burst, prio, !fill_store && (i == size - 1));
      end
   endtask

   // One random phase with the given idle chances for sender and receiver. Now and then
   // the sender holds off until the block has delivered everything.
   task automatic random_phase(input int send_pct, input int recv_pct);
      int target;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      target = jobs_sent + RANDOM_JOBS_PER_PHASE;
      while (jobs_sent < target) begin
         run_random_batch();
         if ($urandom_range(9) == 0) begin
            drain_results();
         end
      end
      drain_results();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // A batch of one job with the largest burst and priority number.
      send_job('1, '1, 1'b1);
      drain_results();

      // A short batch with ties and extremes: the zero-priority job must jump ahead and the
      // two jobs of equal priority must keep their arrival order.
      send_job(16'h0000, 8'h80, 1'b0);
      send_job(16'hFFFF, 8'h00, 1'b0);
      send_job(16'h1234, 8'h80, 1'b0);
      send_job(16'h8001, 8'hFF, 1'b1);
      drain_results();

      // A full store with the last flag never set: the sixteenth job closes the batch.
      // Falling priorities in pairs make each insertion walk the store, with ties.
      for (int i = 0; i < JOB_SLOTS; i++) begin
         send_job((i % 2 == 0) ? 16'hFFFF : 16'(i), 8'(255 - 16 * (i / 2)), 1'b0);
      end
      drain_results();

      random_phase(23, 77);
      random_phase(77, 23);
      random_phase(0, 0);

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[priority_batch_scheduler.f]
src/pbs_pkg.sv
src/pbs_job_ram.sv
src/priority_batch_scheduler.sv
tb/sv/priority_batch_checker.sv
tb/sv/priority_batch_scheduler_test.sv
